FILE: rtl/ssd_pkg.sv
// Package for the sparse set with swap-delete: widths, codes, word types and
// the memory port structs shared by the controller and the top level.
// No dependencies.
package ssd_pkg;

    localparam int KEY_SPACE = 4096;
    localparam int KEY_W     = 12;
    localparam int CNT_W     = 13;
    localparam int ROK_W     = KEY_W + 1;

    localparam logic [CNT_W-1:0] KEY_SPACE_C = CNT_W'(KEY_SPACE);

    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic             want_active;
        logic [KEY_W-1:0] row;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0] fetched_key;
        logic             fetch_ok;
        logic [1:0]       action;
        logic [CNT_W-1:0] member_count;
    } rsp_t;

    // Port of the key-to-row memory: {member flag, row} per key.
    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] waddr;
        logic [ROK_W-1:0] wdata;
        logic [KEY_W-1:0] raddr;
    } rok_port_t;

    // Port of the row-to-key memory.
    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [KEY_W-1:0] raddr;
    } kar_port_t;

endpackage

FILE: rtl/ssd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ssd_ctrl.sv
// Sequencer for the sparse set: clearing pass, read of both memories, then
// the append or swap-delete write-back and the result register.
// Depends on ssd_pkg.
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    output rok_port_t        rok_port,
    input  logic [ROK_W-1:0] rok_rdata,
    output kar_port_t        kar_port,
    input  logic [KEY_W-1:0] kar_rdata
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DROP
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t             item_reg, item_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    req_t             cur;
    logic             accept;
    logic             out_free;
    logic [KEY_W-1:0] last_row;
    logic             flag;
    logic [KEY_W-1:0] hole;
    logic             row_ok;
    logic             do_add;
    logic             do_rem;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The read addresses come straight from the word while idle and from
    // the held word afterwards, so the read data stays put while waiting.
    assign cur      = (state_reg == ST_IDLE) ? req : item_reg;
    assign last_row = KEY_W'(count_reg - CNT_W'(1));

    assign flag   = rok_rdata[KEY_W];
    assign hole   = rok_rdata[KEY_W-1:0];
    assign row_ok = ({1'b0, item_reg.row} < count_reg);
    assign do_add = (item_reg.func == FUNC_SET) && item_reg.want_active && !flag
                    && (count_reg < KEY_SPACE_C);
    assign do_rem = (item_reg.func == FUNC_SET) && !item_reg.want_active && flag
                    && (count_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        rok_port       = '0;
        rok_port.raddr = cur.key;
        kar_port       = '0;
        kar_port.raddr = (cur.func == FUNC_FETCH) ? cur.row : last_row;

        case (state_reg)
            ST_CLEAR:
            begin
                rok_port.we    = 1'b1;
                rok_port.waddr = clr_reg;
                clr_next       = clr_reg + KEY_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_next              = '0;
                    rsp_next.member_count = count_reg;
                    if (item_reg.func == FUNC_FETCH)
                    begin
                        rsp_next.fetch_ok    = row_ok;
                        rsp_next.fetched_key = row_ok ? kar_rdata : '0;
                    end
                    else if (do_add)
                    begin
                        rok_port.we           = 1'b1;
                        rok_port.waddr        = item_reg.key;
                        rok_port.wdata        = {1'b1, count_reg[KEY_W-1:0]};
                        kar_port.we           = 1'b1;
                        kar_port.waddr        = count_reg[KEY_W-1:0];
                        kar_port.wdata        = item_reg.key;
                        count_next            = count_reg + CNT_W'(1);
                        rsp_next.action       = ACT_APPEND;
                        rsp_next.member_count = count_reg + CNT_W'(1);
                    end
                    else if (do_rem)
                    begin
                        // The last key moves into the hole and learns its new row.
                        kar_port.we           = 1'b1;
                        kar_port.waddr        = hole;
                        kar_port.wdata        = kar_rdata;
                        rok_port.we           = 1'b1;
                        rok_port.waddr        = kar_rdata;
                        rok_port.wdata        = {1'b1, hole};
                        count_next            = count_reg - CNT_W'(1);
                        rsp_next.action       = ACT_REMOVE;
                        rsp_next.member_count = count_reg - CNT_W'(1);
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = do_rem ? ST_DROP : ST_IDLE;
                end
            end
            ST_DROP:
            begin
                // Clear the flag of the removed key; this comes after the move
                // so that removing the last row still leaves the key absent.
                rok_port.we    = 1'b1;
                rok_port.waddr = item_reg.key;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            item_reg      <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            item_reg      <= item_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

FILE: rtl/sparse_set_swap_delete.sv
// Sparse set with swap-delete. The result word is registered, and a word waits to
// finish while an older result sits stalled. A fetch, an append or an update
// that changes nothing first reads both memories and then writes back; a removal
// adds a further step that clears the removed key's flag. A new request word is
// taken only once the previous one is done. Reset: the count is zero at once; a
// clearing pass of the flags of all 4096 keys holds req_stall high.
module sparse_set_swap_delete
    import ssd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Two memories hold all the state. The key memory keeps, for every key,
    // a member flag and the row where that key sits in the dense list. The
    // row memory keeps the dense list itself. Only the key memory has a
    // defined reset, which the clearing pass provides; the dense list needs
    // none, since rows at or above the count are never reported.

    rok_port_t        rok_port;
    logic [ROK_W-1:0] rok_rdata;
    kar_port_t        kar_port;
    logic [KEY_W-1:0] kar_rdata;

    // An update word first reads the key memory at the key and the row memory
    // at the last row. The write-back step then decides: append writes both
    // memories at the tail, removal moves the last key into the freed row and
    // repairs its row entry, then a separate step clears the removed key's
    // flag. A fetch word reads the row memory at its row.
    // Words are handled one at a time, so a write always lands before the
    // next read and no forwarding is needed. The result register lets the
    // next request word in while a finished word still waits downstream.
    ssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rok_port  (rok_port),
        .rok_rdata (rok_rdata),
        .kar_port  (kar_port),
        .kar_rdata (kar_rdata)
    );

    ssd_ram #(
        .WIDTH (ROK_W),
        .DEPTH (KEY_SPACE)
    ) u_rok_ram (
        .clk   (clk),
        .we    (rok_port.we),
        .waddr (rok_port.waddr),
        .wdata (rok_port.wdata),
        .raddr (rok_port.raddr),
        .rdata (rok_rdata)
    );

    ssd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_SPACE)
    ) u_kar_ram (
        .clk   (clk),
        .we    (kar_port.we),
        .waddr (kar_port.waddr),
        .wdata (kar_port.wdata),
        .raddr (kar_port.raddr),
        .rdata (kar_rdata)
    );

endmodule

FILE: rtl/ssd_check.sv
// Port-level checks for the sparse set, attached to the top level by bind.
// Depends on ssd_pkg and sparse_set_swap_delete.
module ssd_check
    import ssd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // One word at a time: an accepted request stalls the next one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while the previous one is in progress");

    // A successful fetch never changes membership.
    a_fetch_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fetch_ok |-> rsp.action == ACT_NONE)
        else $error("fetch result reports a membership change");

    // A failed fetch or an update returns a zero key.
    a_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.fetch_ok |-> rsp.fetched_key == '0)
        else $error("nonzero key without a valid fetch");

    // The count never exceeds the key space, and an append leaves it nonzero.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.member_count <= KEY_SPACE_C
            && (rsp.action != ACT_APPEND || rsp.member_count != '0))
        else $error("member count out of range");

endmodule

bind sparse_set_swap_delete ssd_check u_ssd_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
